/* design/spq_pkg.sv */
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int TAG_BITS_DEF = 16;
    localparam int ID_BITS      = 16;
    localparam int TAG_W        = 16;
    localparam int PEND_W       = 5;

    localparam logic             KIND_OPEN  = 1'b0;
    localparam logic             KIND_SERVE = 1'b1;
    localparam logic [ID_BITS-1:0] ID_MAX   = {ID_BITS{1'b1}};
    localparam logic [1:0]       PRI_DEFAULT = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    typedef struct packed {
        logic             kind;
        logic [2:0]       priority_req;
        logic [TAG_W-1:0] payload_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_BITS-1:0] ticket_id;
        logic [1:0]         ticket_priority;
        logic [TAG_W-1:0]   ticket_tag;
        logic [PEND_W-1:0]  pending_count;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } spq_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } spq_stat_t;

    function automatic logic [1:0] norm_priority(input logic [2:0] p);
        logic [1:0] r;
        begin
            if (p >= 3'd1 && p <= 3'd3)
            begin
                r = p[1:0];
            end
            else
            begin
                r = PRI_DEFAULT;
            end
            return r;
        end
    endfunction

endpackage

/* design/spq_ctrl.sv */
module spq_ctrl
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  spq_stat_t stat,
    output spq_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = req_valid;
                if (req_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = stat.need_scan;
                if (!stat.need_scan || stat.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // result register is free or being emptied this cycle
                cmd.commit = !rsp_valid_reg || rsp_ready;
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

/* design/spq_dp.sv */
module spq_dp
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_t      req,
    input  spq_cmd_t  cmd,
    output spq_stat_t stat,
    output rsp_t      rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    logic [ID_BITS-1:0] slot_id_reg  [CAPACITY];
    logic [1:0]         slot_pri_reg [CAPACITY];
    logic [TW-1:0]      slot_tag_reg [CAPACITY];

    logic [CW-1:0]      count_reg, count_next;
    logic               kind_reg;
    logic [1:0]         pri_reg;
    logic [TW-1:0]      tag_reg;
    logic [IW-1:0]      idx_reg;
    logic [ID_BITS-1:0] max_reg;
    rsp_t               rsp_reg, rsp_next;

    logic               is_full;
    logic               do_insert;
    logic               do_remove;
    logic [ID_BITS-1:0] new_id;
    logic [CAPACITY-1:0] keep;

    assign is_full = (count_reg == CW'(CAPACITY));
    assign new_id  = max_reg + ID_BITS'(1);

    assign stat.need_scan = (kind_reg == KIND_OPEN) && !is_full && (count_reg != '0);
    assign stat.scan_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // sorted highest first, so keep is a prefix of the queued slots
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            keep[i] = (CW'(i) < count_reg) && (slot_pri_reg[i] >= pri_reg);
        end
    end

    always_comb
    begin
        rsp_next   = '0;
        do_insert  = 1'b0;
        do_remove  = 1'b0;
        count_next = count_reg;
        if (kind_reg == KIND_SERVE)
        begin
            if (count_reg == '0)
            begin
                rsp_next.status = ST_EMPTY;
            end
            else
            begin
                do_remove                = 1'b1;
                count_next               = count_reg - CW'(1);
                rsp_next.status          = ST_OK;
                rsp_next.ticket_id       = slot_id_reg[0];
                rsp_next.ticket_priority = slot_pri_reg[0];
                rsp_next.ticket_tag      = TAG_W'(slot_tag_reg[0]);
            end
        end
        else if (is_full)
        begin
            rsp_next.status = ST_FULL;
        end
        else if (max_reg == ID_MAX)
        begin
            rsp_next.status = ST_EXHAUSTED;
        end
        else
        begin
            do_insert                = 1'b1;
            count_next               = count_reg + CW'(1);
            rsp_next.status          = ST_OK;
            rsp_next.ticket_id       = new_id;
            rsp_next.ticket_priority = pri_reg;
            rsp_next.ticket_tag      = TAG_W'(tag_reg);
        end
        rsp_next.pending_count = PEND_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req.kind;
            pri_reg  <= norm_priority(req.priority_req);
            tag_reg  <= req.payload_tag[TW-1:0];
            idx_reg  <= '0;
            max_reg  <= '0;
        end
        else if (cmd.scan)
        begin
            idx_reg <= idx_reg + IW'(1);
            if (slot_id_reg[idx_reg] > max_reg)
            begin
                max_reg <= slot_id_reg[idx_reg];
            end
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && do_insert)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (!keep[i])
                begin
                    if (i == 0 || keep[(i == 0) ? 0 : i - 1])
                    begin
                        slot_id_reg[i]  <= new_id;
                        slot_pri_reg[i] <= pri_reg;
                        slot_tag_reg[i] <= tag_reg;
                    end
                    else
                    begin
                        slot_id_reg[i]  <= slot_id_reg[(i == 0) ? 0 : i - 1];
                        slot_pri_reg[i] <= slot_pri_reg[(i == 0) ? 0 : i - 1];
                        slot_tag_reg[i] <= slot_tag_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end
        else if (cmd.commit && do_remove)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                slot_id_reg[i]  <= slot_id_reg[i + 1];
                slot_pri_reg[i] <= slot_pri_reg[i + 1];
                slot_tag_reg[i] <= slot_tag_reg[i + 1];
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

/* design/stable_priority_ticket_queue.sv */
// channel  dir  handshake              payload
// req      in   req_valid / req_ready  req  (kind, priority_req, payload_tag)
// rsp      out  rsp_valid / rsp_ready  rsp  (status, id, priority, tag, count)
//
// a serve, or an open on a full or empty queue, goes through accept, check and commit
// any other open walks the queued slots one per cycle for the largest identifier,
// then commits; the insert is the commit
// one request is in flight at a time; the result beat is valid after the commit
// a result beat waiting on rsp_ready holds the next one in its commit cycle
// rst_n empties the queue; slot contents are not cleared
module stable_priority_ticket_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    spq_cmd_t  cmd;
    spq_stat_t stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_dp #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_OK |->
            rsp.ticket_id != '0 && rsp.ticket_priority != 2'd0)
        else $error("ok result with zero identifier or priority");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |->
            rsp.ticket_id == '0 && rsp.ticket_priority == 2'd0 && rsp.ticket_tag == '0)
        else $error("error result carries entry fields");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.pending_count == PEND_W'(CAPACITY))
        else $error("full status with queue not at capacity");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while one is in flight");

endmodule
